// File: rtl/core/btff_pkg.sv
// btff_pkg: shared constants, codes and types of the boundary-tag allocator
// used by btff_ctrl, btff_dpath, the top level and the checker
`default_nettype none

package btff_pkg;

  localparam int DEF_POOL_WORDS = 4096;
  localparam int MIN_SPLIT      = 3;
  localparam int TAG_WORDS      = 2;
  localparam int BYTES_PER_WORD = 4;
  localparam int BYTE_SHIFT     = 2;

  localparam int BYTES_W  = 14;
  localparam int IDX_W    = 12;
  localparam int STATUS_W = 2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_NULL = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_A_TEST,
    S_A_CHK,
    S_A_SPLIT,
    S_A_SPLIT2,
    S_A_MARK,
    S_F_TEST,
    S_F_B,
    S_F_FAR,
    S_M_RD,
    S_M_SZ,
    S_M_NX,
    S_F_PREV,
    S_F_PV,
    S_PUT_A,
    S_PUT_B,
    S_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_ACCEPT,
    OP_READ_C,
    OP_STEP,
    OP_HAVE,
    OP_PUT_WANT,
    OP_PUT_REM,
    OP_PUT_USED,
    OP_READ_FAR,
    OP_PUT_FREE,
    OP_READ_X,
    OP_READ_NX,
    OP_PUT_MERGE,
    OP_READ_END,
    OP_SET_PREV,
    OP_WR_A,
    OP_WR_B,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic in_free;
    logic clr_last;
    logic c_end;
    logic fits;
    logic split;
    logic null_free;
    logic b_bad;
    logic far_match;
    logic put_ok;
    logic sz_neg;
    logic nx_ok;
    logic nsz_pos;
    logic c_pos;
    logic prev_ok;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/btff_ctrl.sv
// btff_ctrl: sequencer of the allocator, walks, puts tags and merges
// depends on btff_pkg; drives btff_dpath through cmd_t and reads stat_t
`default_nettype none

module btff_ctrl import btff_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t  state_r, state_nxt;
  state_t  ret_r, ret_nxt;
  status_t res_r, res_nxt;
  logic    second_r, second_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    slot_free;
  state_t  mret;

  assign slot_free = !out_valid_r || !out_stall;
  assign mret      = second_r ? S_OUT : S_F_PREV;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      ret_r       <= S_IDLE;
      res_r       <= ST_OK;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      res_r       <= res_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    res_nxt    = res_r;
    second_nxt = second_r;
    unique case (state_r)
      S_CLR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = ST_OK;
          state_nxt = stat.in_free ? S_F_TEST : S_A_TEST;
        end
      end
      S_A_TEST: begin
        if (stat.c_end) begin
          res_nxt   = ST_OOM;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        state_nxt = stat.fits ? S_A_SPLIT : S_A_TEST;
      end
      S_A_SPLIT: begin
        if (stat.split) begin
          ret_nxt   = S_A_SPLIT2;
          state_nxt = S_PUT_A;
        end else begin
          state_nxt = S_A_MARK;
        end
      end
      S_A_SPLIT2: begin
        ret_nxt   = S_A_MARK;
        state_nxt = S_PUT_A;
      end
      S_A_MARK: begin
        ret_nxt   = S_OUT;
        state_nxt = S_PUT_A;
      end
      S_F_TEST: begin
        if (stat.null_free) begin
          res_nxt   = ST_NULL;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_F_B;
        end
      end
      S_F_B: begin
        if (stat.b_bad) begin
          res_nxt   = ST_BAD;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_F_FAR;
        end
      end
      S_F_FAR: begin
        if (stat.far_match) begin
          ret_nxt    = S_M_RD;
          second_nxt = 1'b0;
          state_nxt  = S_PUT_A;
        end else begin
          res_nxt   = ST_BAD;
          state_nxt = S_OUT;
        end
      end
      S_M_RD: begin
        state_nxt = S_M_SZ;
      end
      S_M_SZ: begin
        state_nxt = (stat.sz_neg || !stat.nx_ok) ? mret : S_M_NX;
      end
      S_M_NX: begin
        if (stat.nsz_pos) begin
          ret_nxt   = mret;
          state_nxt = S_PUT_A;
        end else begin
          state_nxt = mret;
        end
      end
      S_F_PREV: begin
        second_nxt = 1'b1;
        state_nxt  = stat.c_pos ? S_F_PV : S_OUT;
      end
      S_F_PV: begin
        state_nxt = stat.prev_ok ? S_M_RD : S_OUT;
      end
      S_PUT_A: begin
        state_nxt = stat.put_ok ? S_PUT_B : ret_r;
      end
      S_PUT_B: begin
        state_nxt = ret_r;
      end
      S_OUT: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (state_r == S_OUT && slot_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // outputs
  always_comb begin
    cmd.op     = OP_NONE;
    cmd.status = res_r;
    unique case (state_r)
      S_CLR:      cmd.op = OP_CLR;
      S_IDLE:     if (in_valid) cmd.op = OP_ACCEPT;
      S_A_TEST:   if (!stat.c_end) cmd.op = OP_READ_C;
      S_A_CHK:    cmd.op = stat.fits ? OP_HAVE : OP_STEP;
      S_A_SPLIT:  if (stat.split) cmd.op = OP_PUT_WANT;
      S_A_SPLIT2: cmd.op = OP_PUT_REM;
      S_A_MARK:   cmd.op = OP_PUT_USED;
      S_F_TEST:   if (!stat.null_free) cmd.op = OP_READ_C;
      S_F_B:      if (!stat.b_bad) cmd.op = OP_READ_FAR;
      S_F_FAR:    if (stat.far_match) cmd.op = OP_PUT_FREE;
      S_M_RD:     cmd.op = OP_READ_X;
      S_M_SZ:     if (!stat.sz_neg && stat.nx_ok) cmd.op = OP_READ_NX;
      S_M_NX:     if (stat.nsz_pos) cmd.op = OP_PUT_MERGE;
      S_F_PREV:   if (stat.c_pos) cmd.op = OP_READ_END;
      S_F_PV:     if (stat.prev_ok) cmd.op = OP_SET_PREV;
      S_PUT_A:    if (stat.put_ok) cmd.op = OP_WR_A;
      S_PUT_B:    cmd.op = OP_WR_B;
      S_OUT:      if (slot_free) cmd.op = OP_OUT;
      default:    cmd.op = OP_NONE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/core/btff_dpath.sv
// btff_dpath: tag memory, chunk pointers, tag arithmetic and result registers
// depends on btff_pkg; executes cmd_t from btff_ctrl and reports stat_t
`default_nettype none

module btff_dpath import btff_pkg::*; #(
  parameter int POOL_WORDS = DEF_POOL_WORDS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  output stat_t                    stat,
  input  wire logic                in_func,
  input  wire logic [BYTES_W-1:0]  in_request_bytes,
  input  wire logic [IDX_W-1:0]    in_free_index,
  output logic [STATUS_W-1:0]      out_status,
  output logic [IDX_W-1:0]         out_grant_index,
  output logic [IDX_W-1:0]         out_grant_words
);

  localparam int AW = $clog2(POOL_WORDS);
  localparam int TW = AW + 1;
  localparam int XW = (AW + 3 > BYTES_W + 1) ? AW + 3 : BYTES_W + 1;

  localparam logic signed [XW-1:0] POOL_X  = XW'(POOL_WORDS);
  localparam logic signed [XW-1:0] ONE_X   = XW'(1);
  localparam logic signed [XW-1:0] TAGW_X  = XW'(TAG_WORDS);
  localparam logic signed [XW-1:0] SPLIT_X = XW'(MIN_SPLIT);
  localparam logic [AW-1:0]        LAST_A  = AW'(POOL_WORDS - 1);
  localparam logic [TW-1:0]        INIT_T  = TW'(POOL_WORDS - TAG_WORDS);
  localparam logic [BYTES_W:0]     ROUND_B = (BYTES_W + 1)'(BYTES_PER_WORD - 1);

  function automatic logic signed [XW-1:0] mag_f(input logic signed [XW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  logic [TW-1:0]        mem_q [POOL_WORDS];
  logic [TW-1:0]        rdata_r;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [TW-1:0]        mem_wd;

  logic [AW-1:0]        clr_r;
  logic                 func_r;
  logic [IDX_W-1:0]     fidx_r;
  logic signed [XW-1:0] c_r, want_r, have_r, got_r, x_r, pa_r, pv_r;
  status_t              status_r;
  logic [IDX_W-1:0]     gidx_r, gwords_r;

  logic signed [XW-1:0] tag, tag_mag, pv_mag;
  logic signed [XW-1:0] c_step, c_far, c_plus1, want_far, put_far, nx, prev, fidx_x;
  logic [BYTES_W:0]     bytes_up;
  logic signed [XW-1:0] want_in;

  assign tag      = XW'(signed'(rdata_r));
  assign tag_mag  = mag_f(tag);
  assign pv_mag   = mag_f(pv_r);
  assign c_step   = c_r + tag_mag + TAGW_X;
  assign c_far    = c_r + ONE_X + tag_mag;
  assign c_plus1  = c_r + ONE_X;
  assign want_far = c_r + ONE_X + want_r;
  assign put_far  = pa_r + ONE_X + pv_mag;
  assign nx       = x_r + tag + TAGW_X;
  assign prev     = c_r - TAGW_X - tag_mag;
  assign fidx_x   = XW'(fidx_r);
  assign bytes_up = {1'b0, in_request_bytes} + ROUND_B;

  always_comb begin
    want_in = XW'(bytes_up >> BYTE_SHIFT);
    if (want_in == '0) want_in = ONE_X;
  end

  always_comb begin
    stat.in_free   = (in_func == FUNC_FREE);
    stat.clr_last  = (clr_r == LAST_A);
    stat.c_end     = (c_r >= POOL_X);
    stat.fits      = (tag >= want_r);
    stat.split     = (have_r > want_r + SPLIT_X);
    stat.null_free = (fidx_r == '0) || (fidx_x >= POOL_X);
    stat.b_bad     = (tag >= 0) || (c_far >= POOL_X);
    stat.far_match = (tag == have_r);
    stat.put_ok    = (put_far < POOL_X);
    stat.sz_neg    = (tag < 0);
    stat.nx_ok     = (nx < POOL_X);
    stat.nsz_pos   = (tag > 0);
    stat.c_pos     = (c_r > 0);
    stat.prev_ok   = (prev >= 0);
  end

  // memory port select
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = pa_r[AW-1:0];
    mem_wd = pv_r[TW-1:0];
    mem_ra = c_r[AW-1:0];
    unique case (cmd.op)
      OP_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = (clr_r == '0 || clr_r == LAST_A) ? INIT_T : '0;
      end
      OP_READ_C: begin
        mem_re = 1'b1;
      end
      OP_READ_FAR: begin
        mem_re = 1'b1;
        mem_ra = c_far[AW-1:0];
      end
      OP_READ_X: begin
        mem_re = 1'b1;
        mem_ra = x_r[AW-1:0];
      end
      OP_READ_NX: begin
        mem_re = 1'b1;
        mem_ra = nx[AW-1:0];
      end
      OP_READ_END: begin
        mem_re = 1'b1;
        mem_ra = c_r[AW-1:0] - AW'(1);
      end
      OP_WR_A: begin
        mem_we = 1'b1;
      end
      OP_WR_B: begin
        mem_we = 1'b1;
        mem_wa = put_far[AW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem_q[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.op == OP_CLR) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        func_r <= in_func;
        fidx_r <= in_free_index;
        want_r <= want_in;
        c_r    <= (in_func == FUNC_FREE) ? XW'(in_free_index) - ONE_X : '0;
      end
      OP_STEP: begin
        c_r <= c_step;
      end
      OP_HAVE: begin
        have_r <= tag;
        got_r  <= tag;
      end
      OP_PUT_WANT: begin
        pa_r <= c_r;
        pv_r <= want_r;
        if (want_far < POOL_X) got_r <= want_r;
      end
      OP_PUT_REM: begin
        pa_r <= c_r + want_r + TAGW_X;
        pv_r <= have_r - want_r - TAGW_X;
      end
      OP_PUT_USED: begin
        pa_r <= c_r;
        pv_r <= -got_r;
      end
      OP_READ_FAR: begin
        have_r <= tag;
      end
      OP_PUT_FREE: begin
        pa_r <= c_r;
        pv_r <= -have_r;
        x_r  <= c_r;
      end
      OP_READ_NX: begin
        have_r <= tag;
      end
      OP_PUT_MERGE: begin
        pa_r <= x_r;
        pv_r <= have_r + tag + TAGW_X;
      end
      OP_SET_PREV: begin
        x_r <= prev;
      end
      OP_OUT: begin
        status_r <= cmd.status;
        if (cmd.status == ST_OK && func_r == FUNC_ALLOC) begin
          gidx_r   <= c_plus1[IDX_W-1:0];
          gwords_r <= got_r[IDX_W-1:0];
        end else begin
          gidx_r   <= '0;
          gwords_r <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_status      = status_r;
  assign out_grant_index = gidx_r;
  assign out_grant_words = gwords_r;

endmodule

`default_nettype wire

// File: rtl/core/boundary_tag_first_fit_allocator_top.sv
// allocate: accept, a read and a fit check per chunk visited, a split check, tag-pair writes, then the result
// free: a run of merge reads and tag writes on the one tag memory
// one request at a time; the next beat is taken once the result sits in the output register
// after reset a clearing pass over all POOL_WORDS tag words holds in_stall high
// reset: synchronous, active low; the result register is empty after reset
// top level of the boundary-tag first-fit allocator; depends on btff_pkg,
// btff_ctrl and btff_dpath
`default_nettype none

module boundary_tag_first_fit_allocator_top import btff_pkg::*; #(
  parameter int POOL_WORDS = DEF_POOL_WORDS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_func,
  input  wire logic [BYTES_W-1:0]  in_request_bytes,
  input  wire logic [IDX_W-1:0]    in_free_index,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [IDX_W-1:0]         out_grant_index,
  output logic [IDX_W-1:0]         out_grant_words
);

  cmd_t  cmd;
  stat_t stat;

  btff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  btff_dpath #(
    .POOL_WORDS (POOL_WORDS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_func),
    .in_request_bytes (in_request_bytes),
    .in_free_index    (in_free_index),
    .out_status       (out_status),
    .out_grant_index  (out_grant_index),
    .out_grant_words  (out_grant_words)
  );

endmodule

`default_nettype wire

// File: rtl/core/btff_checker.sv
// btff_checker: port-level assertions of the allocator top level
// depends on btff_pkg; bound to boundary_tag_first_fit_allocator_top
`default_nettype none

module btff_checker import btff_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [IDX_W-1:0]    out_grant_index,
  input wire logic [IDX_W-1:0]    out_grant_words
);

  // clearing pass follows reset
  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken right after reset");

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while busy");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_grant_index == '0 && out_grant_words == '0)
    else $error("grant fields set on a failed request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

endmodule

bind boundary_tag_first_fit_allocator_top btff_checker u_btff_checker (.*);

`default_nettype wire

// File: sim/boundary_tag_first_fit_allocator_top_tb.sv
// testbench for boundary_tag_first_fit_allocator_top: directed and random allocate/free beats
// checked against a tag-level heap predictor; depends on btff_pkg and the rtl top level
`timescale 1ns / 100ps

module boundary_tag_first_fit_allocator_top_tb;
  import btff_pkg::*;

  localparam int POOL = DEF_POOL_WORDS;
  localparam int MAX_LIVE = 120;

  typedef struct {
    status_t         status;
    logic [IDX_W-1:0] grant_index;
    logic [IDX_W-1:0] grant_words;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = FUNC_ALLOC;
  logic [BYTES_W-1:0] in_request_bytes = '0;
  logic [IDX_W-1:0] in_free_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [IDX_W-1:0] out_grant_index;
  logic [IDX_W-1:0] out_grant_words;

  int heap_tag [POOL];
  reply_t reply_q [$];
  int live_q [$];
  int last_freed = 0;

  int idle_pct = 29;
  int hold_left = 0;
  int fail_count = 0;
  int mismatch_count = 0;
  int n_sent = 0, n_grant = 0, n_oom = 0, n_freed = 0, n_null = 0, n_bad = 0;

  boundary_tag_first_fit_allocator_top #(
    .POOL_WORDS(POOL)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_request_bytes(in_request_bytes),
    .in_free_index   (in_free_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_grant_index (out_grant_index),
    .out_grant_words (out_grant_words)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("timeout with %0d replies outstanding", reply_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // heap predictor
  function automatic void heap_reset();
    foreach (heap_tag[i]) heap_tag[i] = 0;
    heap_tag[0] = POOL - TAG_WORDS;
    heap_tag[POOL-1] = POOL - TAG_WORDS;
  endfunction

  function automatic int tag_rd(int i);
    if (i < 0 || i >= POOL) return 0;
    return heap_tag[i];
  endfunction

  function automatic int tag_mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void tag_put(int c, int v);
    int far_end;
    far_end = c + 1 + tag_mag(v);
    if (c < 0 || far_end >= POOL) return;
    heap_tag[c] = v;
    heap_tag[far_end] = v;
  endfunction

  function automatic int chunk_next(int c);
    return c + tag_mag(tag_rd(c)) + TAG_WORDS;
  endfunction

  function automatic void chunk_merge_up(int c);
    int sz, nx, nsz;
    sz = tag_rd(c);
    if (sz < 0) return;
    nx = chunk_next(c);
    if (nx >= POOL) return;
    nsz = tag_rd(nx);
    if (nsz > 0) tag_put(c, sz + nsz + TAG_WORDS);
  endfunction

  function automatic reply_t heap_predict(logic func, logic [BYTES_W-1:0] nbytes,
                                          logic [IDX_W-1:0] fidx);
    reply_t r;
    int want, c, have, got, b, far_end, tail, prev;
    r.status = ST_OK;
    r.grant_index = '0;
    r.grant_words = '0;
    if (func == FUNC_ALLOC) begin
      want = (int'(nbytes) + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
      if (want == 0) want = 1;
      c = 0;
      while (c < POOL && tag_rd(c) < want) c = chunk_next(c);
      if (c >= POOL) begin
        r.status = ST_OOM;
      end else begin
        have = tag_rd(c);
        if (have > want + MIN_SPLIT) begin
          tag_put(c, want);
          tag_put(c + want + TAG_WORDS, have - want - TAG_WORDS);
        end
        got = tag_rd(c);
        tag_put(c, -got);
        r.grant_index = IDX_W'(c + 1);
        r.grant_words = IDX_W'(got);
      end
    end else if (fidx == 0 || int'(fidx) >= POOL) begin
      r.status = ST_NULL;
    end else begin
      c = int'(fidx) - 1;
      b = tag_rd(c);
      far_end = c + 1 + tag_mag(b);
      if (b >= 0 || far_end >= POOL || tag_rd(far_end) != b) begin
        r.status = ST_BAD;
      end else begin
        tag_put(c, -b);
        chunk_merge_up(c);
        if (c > 0) begin
          tail = c - 1;
          prev = tail - 1 - tag_mag(tag_rd(tail));
          if (prev >= 0) chunk_merge_up(prev);
        end
      end
    end
    return r;
  endfunction

  // result side: random stall, or a long counted hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < idle_pct);
      end
    end
  end

  initial begin : check_replies
    reply_t exp_r;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected reply: status %0d index %0d words %0d",
                     out_status, out_grant_index, out_grant_words);
        end else begin
          exp_r = reply_q.pop_front();
          if (out_status !== exp_r.status || out_grant_index !== exp_r.grant_index ||
              out_grant_words !== exp_r.grant_words) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp status %0d index %0d words %0d, got %0d %0d %0d",
                       exp_r.status, exp_r.grant_index, exp_r.grant_words,
                       out_status, out_grant_index, out_grant_words);
          end
        end
      end
    end
  end

  task automatic send_request(input logic func, input logic [BYTES_W-1:0] nbytes,
                              input logic [IDX_W-1:0] fidx);
    reply_t exp_r;
    int pos;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_request_bytes <= nbytes;
    in_free_index <= fidx;
    do @(posedge clk); while (in_stall);
    exp_r = heap_predict(func, nbytes, fidx);
    reply_q.push_back(exp_r);
    n_sent++;
    case (exp_r.status)
      ST_OOM:  n_oom++;
      ST_NULL: n_null++;
      ST_BAD:  n_bad++;
      default: begin
        if (func == FUNC_ALLOC) begin
          n_grant++;
          live_q.push_back(int'(exp_r.grant_index));
        end else begin
          n_freed++;
          last_freed = int'(fidx);
          for (pos = 0; pos < live_q.size(); pos++) begin
            if (live_q[pos] == int'(fidx)) begin
              live_q.delete(pos);
              break;
            end
          end
        end
      end
    endcase
  endtask

  task automatic alloc_bytes(input int nbytes);
    send_request(FUNC_ALLOC, BYTES_W'(nbytes), '0);
  endtask

  task automatic free_at(input int fidx);
    send_request(FUNC_FREE, BYTES_W'($urandom_range(0, 16383)), IDX_W'(fidx));
  endtask

  task automatic wait_all_replies();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic free_all_live();
    while (live_q.size() != 0) free_at(live_q[0]);
  endtask

  task automatic test_alloc_sizes();
    alloc_bytes(0);
    alloc_bytes(1);
    alloc_bytes(4);
    alloc_bytes(5);
    alloc_bytes(16380);
    alloc_bytes(16383);
  endtask

  task automatic test_free_errors();
    int victim;
    free_at(0);
    free_at(4095);
    victim = live_q[live_q.size()-1];
    free_at(victim + 1);
    free_at(victim);
    free_at(victim);
  endtask

  task automatic test_merge_and_fit();
    int a, b, c;
    free_all_live();
    alloc_bytes(40);
    a = live_q[live_q.size()-1];
    alloc_bytes(40);
    b = live_q[live_q.size()-1];
    alloc_bytes(40);
    c = live_q[live_q.size()-1];
    free_at(b);
    free_at(a);
    // hole of 22 words in front: 21 words leaves too little to split
    alloc_bytes(84);
    free_at(c);
  endtask

  task automatic test_full_pool();
    free_all_live();
    alloc_bytes((POOL - TAG_WORDS) * BYTES_PER_WORD);
    alloc_bytes(0);
    free_all_live();
  endtask

  task automatic test_random_mix(input int count);
    int k, r, sz;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (live_q.size() >= MAX_LIVE && r < 50) r = 60;
      if (r < 50 || (r < 85 && live_q.size() == 0)) begin
        sz = $urandom_range(0, 99);
        if (sz < 75)      alloc_bytes($urandom_range(0, 127));
        else if (sz < 95) alloc_bytes($urandom_range(0, 2047));
        else              alloc_bytes($urandom_range(0, 16383));
      end else if (r < 85) begin
        free_at(live_q[$urandom_range(0, live_q.size() - 1)]);
      end else if (r < 93) begin
        free_at($urandom_range(0, 4095));
      end else if (r < 97) begin
        free_at(last_freed);
      end else if (live_q.size() != 0) begin
        free_at(live_q[$urandom_range(0, live_q.size() - 1)] + $urandom_range(1, 3));
      end else begin
        free_at(0);
      end
    end
  endtask

  task automatic test_quiet_stretch(input int count);
    idle_pct <= 0;
    test_random_mix(count);
    idle_pct <= 29;
  endtask

  task automatic test_backpressure();
    int k;
    hold_left <= 400;
    for (k = 0; k < 8; k++) alloc_bytes($urandom_range(0, 63));
    wait_all_replies();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    heap_reset();
    @(posedge clk);

    test_alloc_sizes();
    test_free_errors();
    test_merge_and_fit();
    test_full_pool();
    wait_all_replies();

    test_random_mix(200);
    test_quiet_stretch(60);
    test_backpressure();
    test_random_mix(180);

    wait_all_replies();
    repeat (64) @(posedge clk);
    fail_count += reply_q.size();

    $display("covered %0d requests: %0d grants, %0d out of memory, %0d frees,",
             n_sent, n_grant, n_oom, n_freed);
    $display("%0d null frees and %0d bad frees, with random and held-off stalls",
             n_null, n_bad);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
